[src/two_link_planar_inverse_kinematics_top_assert.svh]
// Assertion macros shared by the inverse kinematics block.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TWO_LINK_PLANAR_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define TWO_LINK_PLANAR_INVERSE_KINEMATICS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLPIK_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlpik: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLPIK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlpik: next-cycle check failed");

`endif

[src/tlpik_pkg.sv]
package tlpik_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS    = 16;
  localparam int ANG_BITS     = 30;
  localparam int RND_SHIFT    = ANG_BITS - FRAC_BITS;
  localparam int CORDIC_STEPS = 30;
  localparam int SQ_STEPS     = 32;
  localparam int SQ_RAD_W     = 2 * SQ_STEPS;
  localparam int SQ_REM_W     = SQ_STEPS + 3;
  localparam int SQRT_EXTRA   = 28;
  localparam int HALF_SHIFT   = 24;
  localparam int PHI_SHIFT    = 36;
  localparam int CW           = 61;
  localparam int AW           = 34;
  localparam int R2_W         = 36;
  localparam int L4_W         = 34;

  localparam logic [15:0] LINK_LEN_RST = 16'd13926;

  typedef logic signed [17:0]         pos_t;
  typedef logic [15:0]                len_t;
  typedef logic signed [19:0]         thigh_t;
  typedef logic signed [18:0]         knee_t;
  typedef logic [SQ_STEPS-1:0]        root_t;
  typedef logic [SQ_RAD_W-1:0]        rad_t;
  typedef logic [SQ_REM_W-1:0]        rem_t;
  typedef logic signed [CW-1:0]       cval_t;
  typedef logic signed [AW-1:0]       ang_t;

  typedef struct packed {
    logic lim;
    pos_t fx;
    pos_t fz;
  } sq_side_t;

  typedef struct packed {
    logic     vld;
    sq_side_t side;
  } sq_tag_t;

  typedef struct packed {
    logic vld;
    logic lim;
  } cd_tag_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
  } sq_state_t;

  // Arctangent of 2^-i for the first steps, Q2.30 radians.
  localparam ang_t ATAN_LOW [10] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149
  };

  // Quarter-turn pre-rotation angle (twice the first table entry).
  localparam ang_t ROT_ANG = 34'sd1686629712;

  // Rotation angle of CORDIC step i.
  function automatic ang_t atan_step(input int i);
    logic [3:0] idx;
    idx = i[3:0];
    if (i < 10) begin
      return ATAN_LOW[idx];
    end else begin
      return ang_t'((64'sd1 <<< (ANG_BITS - i)) - 64'sd1);
    end
  endfunction

  // One digit of a restoring square root: brings down two radicand bits.
  function automatic sq_state_t sq_step(input sq_state_t s, input logic [1:0] d);
    rem_t      shifted;
    rem_t      trial;
    sq_state_t n;
    shifted = {s.rem[SQ_REM_W-3:0], d};
    trial   = rem_t'({s.root, 2'b01});
    if (shifted >= trial) begin
      n.rem  = shifted - trial;
      n.root = {s.root[SQ_STEPS-2:0], 1'b1};
    end else begin
      n.rem  = shifted;
      n.root = {s.root[SQ_STEPS-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

[src/two_link_planar_inverse_kinematics_top.sv]
// Inverse kinematics for a planar two-link leg with equal link lengths. Each
// request carries a foot target (forward and vertical offset, Q.16 metres) and
// returns the hip and knee angles (Q.16 radians, knee bent, knee <= 0) plus a
// flag set when the reach radius had to be clamped. One request is accepted
// in every cycle while the skid register is empty; an accepted request passes
// through three squaring and clamping stages, a 32-stage square root (one
// root bit per stage) and a 31-stage CORDIC vectoring pipeline, followed by
// the output register. A skid register behind the output lets a finished
// result wait while the pipeline holds.
// The link length register may only be written while no request is in flight.
`include "two_link_planar_inverse_kinematics_top_assert.svh"

module two_link_planar_inverse_kinematics_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  tlpik_pkg::len_t         cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tlpik_pkg::pos_t         in_foot_x,
  input  tlpik_pkg::pos_t         in_foot_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tlpik_pkg::thigh_t       out_thigh_angle,
  output tlpik_pkg::knee_t        out_knee_angle,
  output logic                    out_reach_limited
);

  localparam int RS = tlpik_pkg::RND_SHIFT;
  localparam logic signed [tlpik_pkg::AW:0] ROUND_HALF =
    (tlpik_pkg::AW+1)'(1) <<< (RS - 1);

  tlpik_pkg::len_t link_len_r;
  logic            pipe_en;

  // Link length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_len_r <= tlpik_pkg::LINK_LEN_RST;
    end else if (cfg_wr_en) begin
      link_len_r <= cfg_wr_data;
    end
  end

  // Stage 1: squares of the target offsets and of the reach limits.
  logic [17:0]                    ax, az;
  logic [16:0]                    rmax;
  logic                           v1_r;
  logic [tlpik_pkg::R2_W-1:0]     sqx1_r, sqz1_r;
  logic [tlpik_pkg::L4_W-1:0]     l4_1_r, rm2_1_r;
  tlpik_pkg::pos_t                fx1_r, fz1_r;

  assign ax   = in_foot_x[17] ? 18'(-in_foot_x) : 18'(in_foot_x);
  assign az   = in_foot_z[17] ? 18'(-in_foot_z) : 18'(in_foot_z);
  assign rmax = (link_len_r != '0) ? ({link_len_r, 1'b0} - 17'd1) : 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sqx1_r  <= tlpik_pkg::R2_W'(ax) * tlpik_pkg::R2_W'(ax);
      sqz1_r  <= tlpik_pkg::R2_W'(az) * tlpik_pkg::R2_W'(az);
      l4_1_r  <= tlpik_pkg::L4_W'({32'(link_len_r) * 32'(link_len_r), 2'b00});
      rm2_1_r <= tlpik_pkg::L4_W'(rmax) * tlpik_pkg::L4_W'(rmax);
      fx1_r   <= in_foot_x;
      fz1_r   <= in_foot_z;
    end
  end

  // Stage 2: squared radius.
  logic                           v2_r;
  logic [tlpik_pkg::R2_W-1:0]     r2_2_r;
  logic [tlpik_pkg::L4_W-1:0]     l4_2_r, rm2_2_r;
  tlpik_pkg::pos_t                fx2_r, fz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      r2_2_r  <= sqx1_r + sqz1_r;
      l4_2_r  <= l4_1_r;
      rm2_2_r <= rm2_1_r;
      fx2_r   <= fx1_r;
      fz2_r   <= fz1_r;
    end
  end

  // Stage 3: clamp the squared radius into the reachable range.
  logic [tlpik_pkg::R2_W-1:0]     r2c_nxt;
  logic                           lim_nxt;
  logic                           v3_r;
  logic [tlpik_pkg::R2_W-1:0]     r2c3_r;
  logic [tlpik_pkg::L4_W-1:0]     l4_3_r;
  logic                           lim3_r;
  tlpik_pkg::pos_t                fx3_r, fz3_r;

  always_comb begin
    r2c_nxt = r2_2_r;
    lim_nxt = 1'b0;
    if (r2_2_r == '0) begin
      r2c_nxt = tlpik_pkg::R2_W'(1);
      lim_nxt = 1'b1;
    end else if (r2_2_r > tlpik_pkg::R2_W'(rm2_2_r)) begin
      r2c_nxt = tlpik_pkg::R2_W'(rm2_2_r);
      lim_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      r2c3_r <= r2c_nxt;
      l4_3_r <= l4_2_r;
      lim3_r <= lim_nxt;
      fx3_r  <= fx2_r;
      fz3_r  <= fz2_r;
    end
  end

  // Radicands: the radius and the knee-height term, both scaled up.
  logic [tlpik_pkg::R2_W-1:0] diff;
  tlpik_pkg::rad_t            rad_r2, rad_h2;
  tlpik_pkg::sq_tag_t         sq_in_tag, sq_out_tag;
  tlpik_pkg::root_t           rr, ss;

  assign diff   = (tlpik_pkg::R2_W'(l4_3_r) > r2c3_r) ?
                  (tlpik_pkg::R2_W'(l4_3_r) - r2c3_r) : '0;
  assign rad_r2 = tlpik_pkg::rad_t'(r2c3_r) << tlpik_pkg::SQRT_EXTRA;
  assign rad_h2 = tlpik_pkg::rad_t'(diff) << tlpik_pkg::SQRT_EXTRA;

  assign sq_in_tag.vld      = v3_r;
  assign sq_in_tag.side.lim = lim3_r;
  assign sq_in_tag.side.fx  = fx3_r;
  assign sq_in_tag.side.fz  = fz3_r;

  tlpik_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_tag  (sq_in_tag),
    .rad_a   (rad_r2),
    .rad_b   (rad_h2),
    .out_tag (sq_out_tag),
    .root_a  (rr),
    .root_b  (ss)
  );

  // Angles of the half knee triangle and of the target direction.
  tlpik_pkg::cd_tag_t cd_in_tag, cd_out_tag;
  tlpik_pkg::ang_t    half_ang, phi_ang;

  assign cd_in_tag.vld = sq_out_tag.vld;
  assign cd_in_tag.lim = sq_out_tag.side.lim;

  tlpik_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_tag   (cd_in_tag),
    .rr       (rr),
    .ss       (ss),
    .fx       (sq_out_tag.side.fx),
    .fz       (sq_out_tag.side.fz),
    .out_tag  (cd_out_tag),
    .half_ang (half_ang),
    .phi_ang  (phi_ang)
  );

  // Joint angles, rounded half up to the output precision.
  logic signed [tlpik_pkg::AW:0] thigh_sum, thigh_rnd, knee_dbl, knee_rnd;
  tlpik_pkg::thigh_t             thigh_nxt;
  tlpik_pkg::knee_t              knee_nxt;

  assign thigh_sum = (tlpik_pkg::AW+1)'(phi_ang) + (tlpik_pkg::AW+1)'(half_ang);
  assign thigh_rnd = thigh_sum + ROUND_HALF;
  assign knee_dbl  = {half_ang, 1'b0};
  assign knee_rnd  = knee_dbl + ROUND_HALF;
  assign thigh_nxt = thigh_rnd[RS+19:RS];
  assign knee_nxt  = -knee_rnd[RS+18:RS];

  // Output register with a skid register behind it.
  logic              out_v_r, skid_v_r, out_v_nxt, skid_v_nxt;
  logic              arrive, take, load_out, load_from_skid, load_skid;
  tlpik_pkg::thigh_t out_thigh_r, skid_thigh_r;
  tlpik_pkg::knee_t  out_knee_r, skid_knee_r;
  logic              out_lim_r, skid_lim_r;

  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;
  assign arrive   = cd_out_tag.vld && pipe_en;
  assign take     = out_v_r && out_ready;

  always_comb begin
    out_v_nxt      = out_v_r;
    skid_v_nxt     = skid_v_r;
    load_out       = 1'b0;
    load_from_skid = 1'b0;
    load_skid      = 1'b0;
    if (skid_v_r) begin
      if (take) begin
        load_from_skid = 1'b1;
        skid_v_nxt     = 1'b0;
      end
    end else if (arrive) begin
      if (!out_v_r || take) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_thigh_r <= thigh_nxt;
      out_knee_r  <= knee_nxt;
      out_lim_r   <= cd_out_tag.lim;
    end else if (load_from_skid) begin
      out_thigh_r <= skid_thigh_r;
      out_knee_r  <= skid_knee_r;
      out_lim_r   <= skid_lim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_skid) begin
      skid_thigh_r <= thigh_nxt;
      skid_knee_r  <= knee_nxt;
      skid_lim_r   <= cd_out_tag.lim;
    end
  end

  assign out_valid         = out_v_r;
  assign out_thigh_angle   = out_thigh_r;
  assign out_knee_angle    = out_knee_r;
  assign out_reach_limited = out_lim_r;

  // The skid register only holds a result behind a full output register.
  `TLPIK_ASSERT_HOLDS(a_skid_behind_out, skid_v_r, out_v_r)
  // A result in the skid register stays until the output is taken.
  `TLPIK_ASSERT_NEXT(a_skid_kept, skid_v_r && !out_ready, skid_v_r)
  // A result arriving at a stalled output must land in the skid register.
  `TLPIK_ASSERT_NEXT(a_skid_fill, arrive && out_v_r && !out_ready, skid_v_r)
  // The bent-knee branch never gives a positive knee angle.
  `TLPIK_ASSERT_HOLDS(a_knee_nonpos, out_v_r, out_knee_r[18] || (out_knee_r == '0))

endmodule

[src/tlpik_sqrt.sv]
// Two-lane pipelined integer square root, one result bit per stage.
module tlpik_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tlpik_pkg::sq_tag_t in_tag,
  input  tlpik_pkg::rad_t   rad_a,
  input  tlpik_pkg::rad_t   rad_b,
  output tlpik_pkg::sq_tag_t out_tag,
  output tlpik_pkg::root_t  root_a,
  output tlpik_pkg::root_t  root_b
);

  logic                  vld_r  [tlpik_pkg::SQ_STEPS];
  tlpik_pkg::sq_side_t   side_r [tlpik_pkg::SQ_STEPS];
  tlpik_pkg::sq_state_t  st_r   [2][tlpik_pkg::SQ_STEPS];
  tlpik_pkg::rad_t       rad_r  [2][tlpik_pkg::SQ_STEPS-1];

  for (genvar s = 0; s < tlpik_pkg::SQ_STEPS; s++) begin : g_stage
    logic                 vld_in;
    tlpik_pkg::sq_side_t  side_in;
    tlpik_pkg::rad_t      rad_in [2];
    tlpik_pkg::sq_state_t st_in  [2];
    tlpik_pkg::sq_state_t st_nxt [2];

    if (s == 0) begin : g_first
      assign vld_in    = in_tag.vld;
      assign side_in   = in_tag.side;
      assign rad_in[0] = rad_a;
      assign rad_in[1] = rad_b;
      assign st_in[0]  = '0;
      assign st_in[1]  = '0;
    end else begin : g_next
      assign vld_in    = vld_r[s-1];
      assign side_in   = side_r[s-1];
      assign rad_in[0] = rad_r[0][s-1];
      assign rad_in[1] = rad_r[1][s-1];
      assign st_in[0]  = st_r[0][s-1];
      assign st_in[1]  = st_r[1][s-1];
    end

    // Bring down the next two radicand bits in each lane.
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        st_nxt[l] = tlpik_pkg::sq_step(st_in[l],
                                       rad_in[l][tlpik_pkg::SQ_RAD_W-1 -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s]   <= side_in;
        st_r[0][s]  <= st_nxt[0];
        st_r[1][s]  <= st_nxt[1];
      end
    end

    // The radicand shifts on except after the last digit.
    if (s < tlpik_pkg::SQ_STEPS - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[0][s] <= rad_in[0] << 2;
          rad_r[1][s] <= rad_in[1] << 2;
        end
      end
    end
  end

  assign out_tag.vld  = vld_r[tlpik_pkg::SQ_STEPS-1];
  assign out_tag.side = side_r[tlpik_pkg::SQ_STEPS-1];
  assign root_a       = st_r[0][tlpik_pkg::SQ_STEPS-1].root;
  assign root_b       = st_r[1][tlpik_pkg::SQ_STEPS-1].root;

endmodule

[src/tlpik_cordic.sv]
// Two-lane pipelined CORDIC vectoring: lane 0 gives the half knee angle from
// the two roots, lane 1 the direction of the foot target.
module tlpik_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tlpik_pkg::cd_tag_t in_tag,
  input  tlpik_pkg::root_t  rr,
  input  tlpik_pkg::root_t  ss,
  input  tlpik_pkg::pos_t   fx,
  input  tlpik_pkg::pos_t   fz,
  output tlpik_pkg::cd_tag_t out_tag,
  output tlpik_pkg::ang_t   half_ang,
  output tlpik_pkg::ang_t   phi_ang
);

  localparam int N = tlpik_pkg::CORDIC_STEPS;

  logic             vld_r [N+1];
  logic             lim_r [N+1];
  logic             zr_r  [2][N+1];
  tlpik_pkg::cval_t x_r   [2][N+1];
  tlpik_pkg::cval_t y_r   [2][N+1];
  tlpik_pkg::ang_t  ang_r [2][N+1];

  tlpik_pkg::cval_t xi [2];
  tlpik_pkg::cval_t yi [2];
  tlpik_pkg::cval_t xp_nxt [2];
  tlpik_pkg::cval_t yp_nxt [2];
  tlpik_pkg::ang_t  ap_nxt [2];
  logic             zp_nxt [2];

  // Scale the operands up to the working precision.
  assign yi[0] = tlpik_pkg::cval_t'(ss) <<< tlpik_pkg::HALF_SHIFT;
  assign xi[0] = tlpik_pkg::cval_t'(rr) <<< tlpik_pkg::HALF_SHIFT;
  assign yi[1] = tlpik_pkg::cval_t'(fx) <<< tlpik_pkg::PHI_SHIFT;
  assign xi[1] = -(tlpik_pkg::cval_t'(fz) <<< tlpik_pkg::PHI_SHIFT);

  // Rotate a vector in the left half-plane by a quarter turn first.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      zp_nxt[l] = (xi[l] == '0) && (yi[l] == '0);
      if (xi[l][tlpik_pkg::CW-1]) begin
        if (!yi[l][tlpik_pkg::CW-1]) begin
          xp_nxt[l] = yi[l];
          yp_nxt[l] = -xi[l];
          ap_nxt[l] = tlpik_pkg::ROT_ANG;
        end else begin
          xp_nxt[l] = -yi[l];
          yp_nxt[l] = xi[l];
          ap_nxt[l] = -tlpik_pkg::ROT_ANG;
        end
      end else begin
        xp_nxt[l] = xi[l];
        yp_nxt[l] = yi[l];
        ap_nxt[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lim_r[0] <= in_tag.lim;
      for (int l = 0; l < 2; l++) begin
        zr_r[l][0]  <= zp_nxt[l];
        x_r[l][0]   <= xp_nxt[l];
        y_r[l][0]   <= yp_nxt[l];
        ang_r[l][0] <= ap_nxt[l];
      end
    end
  end

  // One micro-rotation per stage, driving y towards zero.
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam tlpik_pkg::ang_t STEP_ANG = tlpik_pkg::atan_step(k);
    tlpik_pkg::cval_t x_nxt [2];
    tlpik_pkg::cval_t y_nxt [2];
    tlpik_pkg::ang_t  a_nxt [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (!y_r[l][k][tlpik_pkg::CW-1]) begin
          x_nxt[l] = x_r[l][k] + (y_r[l][k] >>> k);
          y_nxt[l] = y_r[l][k] - (x_r[l][k] >>> k);
          a_nxt[l] = ang_r[l][k] + STEP_ANG;
        end else begin
          x_nxt[l] = x_r[l][k] - (y_r[l][k] >>> k);
          y_nxt[l] = y_r[l][k] + (x_r[l][k] >>> k);
          a_nxt[l] = ang_r[l][k] - STEP_ANG;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lim_r[k+1] <= lim_r[k];
        for (int l = 0; l < 2; l++) begin
          zr_r[l][k+1]  <= zr_r[l][k];
          x_r[l][k+1]   <= x_nxt[l];
          y_r[l][k+1]   <= y_nxt[l];
          ang_r[l][k+1] <= a_nxt[l];
        end
      end
    end
  end

  // A zero-length vector has angle zero.
  assign out_tag.vld = vld_r[N];
  assign out_tag.lim = lim_r[N];
  assign half_ang    = zr_r[0][N] ? '0 : ang_r[0][N];
  assign phi_ang     = zr_r[1][N] ? '0 : ang_r[1][N];

endmodule

[tb/ik_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and configuration ports, predicts the joint
// angles for every accepted request and compares them with the results.
module ik_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  tlpik_pkg::len_t   cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tlpik_pkg::pos_t   in_foot_x,
  input  tlpik_pkg::pos_t   in_foot_z,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tlpik_pkg::thigh_t out_thigh_angle,
  input  tlpik_pkg::knee_t  out_knee_angle,
  input  logic              out_reach_limited,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    tlpik_pkg::thigh_t thigh;
    tlpik_pkg::knee_t  knee;
    logic              limited;
  } joint_angles_t;

  joint_angles_t    angle_queue[$];
  tlpik_pkg::len_t  leg_len;
  longint signed    atan_table[10] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149
  };

  // Bit-serial integer square root, floor of the exact root.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitpos;
    root   = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v    = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // CORDIC vectoring arctangent in Q2.30 radians, with a quarter-turn
  // pre-rotation for the left half plane.
  function automatic longint signed vector_angle(input longint signed y,
                                                 input longint signed x);
    longint signed ang;
    longint signed t;
    longint signed dx;
    longint signed dy;
    longint signed step;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        ang = 2 * atan_table[0];
      end else begin
        t = x; x = -y; y = t;
        ang = -2 * atan_table[0];
      end
    end
    for (int i = 0; i < 30; i++) begin
      dx   = y >>> i;
      dy   = x >>> i;
      step = (i < 10) ? atan_table[i] : ((64'sd1 <<< (30 - i)) - 1);
      if (y >= 0) begin
        x = x + dx; y = y - dy; ang = ang + step;
      end else begin
        x = x - dx; y = y + dy; ang = ang - step;
      end
    end
    return ang;
  endfunction

  // Rounds a Q2.30 angle half up to 16 fractional bits.
  function automatic longint signed round_angle(input longint signed a);
    return (a + (64'sd1 <<< 13)) >>> 14;
  endfunction

  // Solves the bent-knee leg for one foot target.
  function automatic joint_angles_t solve_leg(input tlpik_pkg::pos_t fx,
                                              input tlpik_pkg::pos_t fz,
                                              input tlpik_pkg::len_t len);
    joint_angles_t   res;
    longint signed   x;
    longint signed   z;
    longint unsigned r2;
    longint unsigned four_l2;
    longint unsigned rmax;
    longint unsigned rr;
    longint unsigned ss;
    longint signed   half;
    longint signed   phi;
    longint signed   thigh;
    longint signed   knee;
    x           = fx;
    z           = fz;
    r2          = longint'(x * x + z * z);
    four_l2     = 4 * longint'(len) * longint'(len);
    rmax        = (len >= 1) ? 2 * longint'(len) - 1 : 1;
    res.limited = 1'b0;
    if (r2 < 1) begin
      r2 = 1; res.limited = 1'b1;
    end
    if (r2 > rmax * rmax) begin
      r2 = rmax * rmax; res.limited = 1'b1;
    end
    rr    = int_sqrt(r2 << 28);
    ss    = (four_l2 > r2) ? int_sqrt((four_l2 - r2) << 28) : 0;
    half  = vector_angle(longint'(ss << 24), longint'(rr << 24));
    phi   = vector_angle(x <<< 36, (-z) <<< 36);
    thigh = round_angle(phi + half);
    knee  = -round_angle(2 * half);
    res.thigh = tlpik_pkg::thigh_t'(thigh);
    res.knee  = tlpik_pkg::knee_t'(knee);
    return res;
  endfunction

  assign pending = angle_queue.size();

  // Prediction on accepted requests, comparison on accepted results.
  always @(posedge clk) begin
    joint_angles_t want;
    if (!rst_n) begin
      leg_len <= tlpik_pkg::LINK_LEN_RST;
    end else begin
      if (in_valid && in_ready) begin
        angle_queue.push_back(solve_leg(in_foot_x, in_foot_z, leg_len));
      end
      if (out_valid && out_ready) begin
        if (angle_queue.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = angle_queue.pop_front();
          if (out_thigh_angle !== want.thigh) begin
            $error("thigh_angle: expected %0d, got %0d", want.thigh, out_thigh_angle);
            fail_count++;
          end
          if (out_knee_angle !== want.knee) begin
            $error("knee_angle: expected %0d, got %0d", want.knee, out_knee_angle);
            fail_count++;
          end
          if (out_reach_limited !== want.limited) begin
            $error("reach_limited: expected %0d, got %0d", want.limited,
                   out_reach_limited);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) leg_len <= cfg_wr_data;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  tlpik_pkg::len_t   cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  tlpik_pkg::pos_t   in_foot_x;
  tlpik_pkg::pos_t   in_foot_z;
  logic              out_valid;
  logic              out_ready;
  tlpik_pkg::thigh_t out_thigh_angle;
  tlpik_pkg::knee_t  out_knee_angle;
  logic              out_reach_limited;
  int                fail_count;
  int                pending;
  logic              steady;
  int                stall_cycles;
  tlpik_pkg::len_t   cur_len;

  two_link_planar_inverse_kinematics_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_foot_x(in_foot_x), .in_foot_z(in_foot_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_thigh_angle(out_thigh_angle), .out_knee_angle(out_knee_angle),
    .out_reach_limited(out_reach_limited)
  );

  ik_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_foot_x(in_foot_x), .in_foot_z(in_foot_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_thigh_angle(out_thigh_angle), .out_knee_angle(out_knee_angle),
    .out_reach_limited(out_reach_limited),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  // Watchdog: ends the run after a long spell with no handshake at all.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one request and holds it until accepted, then maybe idles.
  task automatic send_target(input tlpik_pkg::pos_t fx, input tlpik_pkg::pos_t fz);
    in_valid  <= 1'b1;
    in_foot_x <= fx;
    in_foot_z <= fz;
    do @(posedge clk); while (!in_ready);
    if (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Lets the pipeline drain, then writes the link length.
  task automatic set_link(input tlpik_pkg::len_t len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    cur_len     = len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random targets: mostly around the reachable disc, some anywhere.
  task automatic random_targets(input int count);
    int span;
    for (int i = 0; i < count; i++) begin
      span = 2 * int'(cur_len) + 4;
      if (span > 131071) span = 131071;
      if ($urandom_range(0, 3) == 0) begin
        send_target(tlpik_pkg::pos_t'($urandom), tlpik_pkg::pos_t'($urandom));
      end else begin
        send_target(tlpik_pkg::pos_t'($urandom_range(0, 2 * span) - span),
                    tlpik_pkg::pos_t'($urandom_range(0, 2 * span) - span));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_foot_x   = '0;
    in_foot_z   = '0;
    steady      = 1'b0;
    cur_len     = tlpik_pkg::LINK_LEN_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed targets at the reset link length.
    send_target(18'sd0, 18'sd0);
    send_target(18'sd131071, 18'sd131071);
    send_target(-18'sd131072, -18'sd131072);
    send_target(-18'sd131072, 18'sd131071);
    send_target(18'sd0, -18'sd27852);
    send_target(18'sd0, -18'sd27851);
    send_target(18'sd0, 18'sd5000);
    send_target(18'sd0, -18'sd5000);
    send_target(18'sd1, 18'sd0);
    send_target(-18'sd1, 18'sd0);
    send_target(18'sd10000, -18'sd15000);
    send_target(-18'sd10000, 18'sd15000);
    send_target(18'sd20000, 18'sd0);
    random_targets(75);

    // Zero link length: knee stays straight, radius one unit is unclamped.
    set_link(16'd0);
    send_target(18'sd1, 18'sd0);
    send_target(18'sd0, 18'sd0);
    send_target(18'sd300, -18'sd400);
    random_targets(60);

    set_link(16'd1);
    random_targets(60);

    // Longest links, beyond the nominal range too.
    set_link(16'd65535);
    send_target(18'sd131071, -18'sd131072);
    send_target(18'sd0, 18'sd131071);
    random_targets(80);

    set_link(16'd32768);
    steady = 1'b1;
    random_targets(100);
    steady = 1'b0;

    set_link(tlpik_pkg::len_t'($urandom_range(1, 65535)));
    random_targets(80);

    set_link(tlpik_pkg::LINK_LEN_RST);
    random_targets(70);

    // Drain and give the verdict.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
